/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* hw/rtl/lcpa_pkg.sv */
// shared types and constants of the lcp array engine
// no dependencies
`default_nettype none

package lcpa_pkg;

  localparam int MAX_TEXT_DEF = 65536;
  localparam int POS_SPACE    = 65536;
  localparam int CFG_W        = 17;
  localparam int POS_W        = 16;
  localparam int SYM_W        = 8;
  localparam int LCP_W        = 16;
  localparam int SUM_W        = 18;

  localparam logic [SYM_W-1:0] SEP_CHAR = 8'h24;
  localparam logic [SYM_W-1:0] UNK_CHAR = 8'h4E;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_RUN  = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] suffix_start;
  } cmd_t;

  typedef struct packed {
    logic [LCP_W-1:0] lcp_value;
    logic             status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_RANK_RD,
    ST_RANK_WR,
    ST_WALK_RANK,
    ST_WALK_K,
    ST_WALK_J,
    ST_CMP_A,
    ST_CMP_B,
    ST_CMP_C,
    ST_STORE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/lcp_array_from_suffix_array.sv */
// top level of the kasai lcp array engine
// depends on lcpa_pkg, lcpa_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// lcp array engine: a text and its suffix array are loaded one entry per
// command word (func load), a run command builds the inverse suffix array and
// walks the text in position order computing longest common prefixes of
// adjacent ranks (kasai), and read commands return the lcp of ranks k and k+1.
// every command word gives exactly one response word. loads, unused funcs and
// refused reads answer from the output register in the cycle after acceptance,
// reads that find a result answer through the registered lcp store read and
// then the output register. a run with effective length n = min(text_length,
// MAX_TEXT, 65536) clears the rank and lcp stores, builds the ranks, then
// walks the positions; each position of nonzero rank extends the carried
// match length until the text end, a mismatch or a terminator, and the
// carried length caps the matching byte pairs of a run at 2n. the byte
// compare loop is bound by the single read port of the text store, which
// serves both compared positions in turn. the engine takes one command at a
// time and accepts the next once its response word has left the output
// register. text_length is written through the cfg port while the engine is
// idle and invalidates earlier results.
module lcp_array_from_suffix_array #(
  parameter int MAX_TEXT = lcpa_pkg::MAX_TEXT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // command channel
  input  wire logic                       cmd_valid,
  output logic                            cmd_stall,
  input  wire lcpa_pkg::cmd_t             cmd,
  // response channel
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output lcpa_pkg::rsp_t                  rsp,
  // text_length register write
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [lcpa_pkg::CFG_W-1:0] cfg_data
);

  // store depth: positions are 16 bits, so at most 64k entries are reachable
  localparam int DEPTH = (MAX_TEXT > lcpa_pkg::POS_SPACE) ? lcpa_pkg::POS_SPACE : MAX_TEXT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;
  localparam int SW    = lcpa_pkg::SUM_W;
  localparam int CW    = lcpa_pkg::CFG_W;

  // sequencer state and walk registers
  lcpa_pkg::state_t state, state_next;
  logic [NW-1:0]    cnt, cnt_next;          // clear / rank / walk position
  logic [NW-1:0]    l, l_next;              // carried match length
  logic [AW-1:0]    kreg, kreg_next;        // rank of current position
  logic [lcpa_pkg::POS_W-1:0] j, j_next;    // suffix of preceding rank
  logic [lcpa_pkg::SYM_W-1:0] ca, ca_next;  // byte at position a
  logic [CW-1:0]    text_length, text_length_next;
  logic             results_ready, results_ready_next;
  logic             rsp_valid_next;
  lcpa_pkg::rsp_t   rsp_next;

  // ram ports
  logic                       t_we, s_we, r_we, p_we;
  logic [AW-1:0]              t_raddr, s_raddr, r_raddr, p_raddr;
  logic [AW-1:0]              r_waddr, p_waddr;
  logic [AW-1:0]              r_wdata;
  logic [lcpa_pkg::LCP_W-1:0] p_wdata;
  logic [lcpa_pkg::SYM_W-1:0] t_rdata;
  logic [lcpa_pkg::POS_W-1:0] s_rdata;
  logic [AW-1:0]              r_rdata;
  logic [lcpa_pkg::LCP_W-1:0] p_rdata;

  logic          cmd_fire, cfg_fire;
  logic [NW-1:0] n;
  logic [SW-1:0] a, b;
  logic          load_ok, read_ok;

  // effective text length, capped at the store depth
  assign n = (text_length > CW'(DEPTH)) ? NW'(DEPTH) : text_length[NW-1:0];

  // compared positions of the current extension step
  assign a = SW'(cnt) + SW'(l);
  assign b = SW'(j) + SW'(l);

  assign cmd_stall = !((state == lcpa_pkg::ST_IDLE) && !rsp_valid);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign cfg_ready = (state == lcpa_pkg::ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign load_ok = ({1'b0, cmd.position} < CW'(DEPTH));
  assign read_ok = results_ready && (({1'b0, cmd.position} + CW'(1)) < CW'(n));

  lcpa_ram #(.WIDTH(lcpa_pkg::SYM_W), .DEPTH(DEPTH)) u_text (
    .clk   (clk),
    .we    (t_we),
    .waddr (cmd.position[AW-1:0]),
    .wdata (cmd.symbol),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  lcpa_ram #(.WIDTH(lcpa_pkg::POS_W), .DEPTH(DEPTH)) u_suffix (
    .clk   (clk),
    .we    (s_we),
    .waddr (cmd.position[AW-1:0]),
    .wdata (cmd.suffix_start),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  lcpa_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_rank (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  lcpa_ram #(.WIDTH(lcpa_pkg::LCP_W), .DEPTH(DEPTH)) u_prefix (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lcpa_pkg::ST_IDLE;
      cnt           <= '0;
      l             <= '0;
      text_length   <= '0;
      results_ready <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      cnt           <= cnt_next;
      l             <= l_next;
      text_length   <= text_length_next;
      results_ready <= results_ready_next;
      rsp_valid     <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kreg <= kreg_next;
    j    <= j_next;
    ca   <= ca_next;
    rsp  <= rsp_next;
  end

  always_comb begin
    state_next         = state;
    cnt_next           = cnt;
    l_next             = l;
    kreg_next          = kreg;
    j_next             = j;
    ca_next            = ca;
    text_length_next   = text_length;
    results_ready_next = results_ready;
    rsp_valid_next     = rsp_valid && rsp_stall;
    rsp_next           = rsp;

    t_we    = 1'b0;
    s_we    = 1'b0;
    r_we    = 1'b0;
    p_we    = 1'b0;
    t_raddr = a[AW-1:0];
    s_raddr = cnt[AW-1:0];
    r_raddr = cnt[AW-1:0];
    p_raddr = cmd.position[AW-1:0];
    r_waddr = cnt[AW-1:0];
    r_wdata = '0;
    p_waddr = cnt[AW-1:0];
    p_wdata = '0;

    unique case (state)
      lcpa_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          unique case (cmd.func)
            lcpa_pkg::FUNC_LOAD: begin
              results_ready_next = 1'b0;
              t_we               = load_ok;
              s_we               = load_ok;
              rsp_next           = '{lcp_value: '0, status: !load_ok};
              rsp_valid_next     = 1'b1;
            end
            lcpa_pkg::FUNC_RUN: begin
              cnt_next   = '0;
              l_next     = '0;
              state_next = lcpa_pkg::ST_CLEAR;
            end
            lcpa_pkg::FUNC_READ: begin
              if (read_ok) begin
                state_next = lcpa_pkg::ST_READ;
              end else begin
                rsp_next       = '{lcp_value: '0, status: 1'b1};
                rsp_valid_next = 1'b1;
              end
            end
            default: begin
              rsp_next       = '{lcp_value: '0, status: 1'b1};
              rsp_valid_next = 1'b1;
            end
          endcase
        end
      end
      lcpa_pkg::ST_READ: begin
        rsp_next       = '{lcp_value: p_rdata, status: 1'b0};
        rsp_valid_next = 1'b1;
        state_next     = lcpa_pkg::ST_IDLE;
      end
      // zero rank and lcp entries below n
      lcpa_pkg::ST_CLEAR: begin
        if (cnt == n) begin
          cnt_next   = '0;
          state_next = lcpa_pkg::ST_RANK_RD;
        end else begin
          r_we     = 1'b1;
          p_we     = 1'b1;
          cnt_next = cnt + NW'(1);
        end
      end
      // inverse suffix array: read each entry, then write its rank if it is below n
      lcpa_pkg::ST_RANK_RD: begin
        if (cnt == n) begin
          cnt_next   = '0;
          state_next = lcpa_pkg::ST_WALK_RANK;
        end else begin
          state_next = lcpa_pkg::ST_RANK_WR;
        end
      end
      lcpa_pkg::ST_RANK_WR: begin
        r_we       = ({1'b0, s_rdata} < CW'(n));
        r_waddr    = s_rdata[AW-1:0];
        r_wdata    = cnt[AW-1:0];
        cnt_next   = cnt + NW'(1);
        state_next = lcpa_pkg::ST_RANK_RD;
      end
      // walk text positions in order
      lcpa_pkg::ST_WALK_RANK: begin
        if (cnt == n) begin
          state_next = lcpa_pkg::ST_DONE;
        end else begin
          state_next = lcpa_pkg::ST_WALK_K;
        end
      end
      lcpa_pkg::ST_WALK_K: begin
        kreg_next = r_rdata;
        s_raddr   = r_rdata - AW'(1);
        if (r_rdata == '0) begin
          l_next     = (l != '0) ? l - NW'(1) : l;
          cnt_next   = cnt + NW'(1);
          state_next = lcpa_pkg::ST_WALK_RANK;
        end else begin
          state_next = lcpa_pkg::ST_WALK_J;
        end
      end
      lcpa_pkg::ST_WALK_J: begin
        j_next     = s_rdata;
        state_next = lcpa_pkg::ST_CMP_A;
      end
      // extension loop: fetch text[a], then text[b], then compare
      lcpa_pkg::ST_CMP_A: begin
        if ((a >= SW'(n)) || (b >= SW'(n))) begin
          state_next = lcpa_pkg::ST_STORE;
        end else begin
          state_next = lcpa_pkg::ST_CMP_B;
        end
      end
      lcpa_pkg::ST_CMP_B: begin
        ca_next    = t_rdata;
        t_raddr    = b[AW-1:0];
        state_next = lcpa_pkg::ST_CMP_C;
      end
      lcpa_pkg::ST_CMP_C: begin
        if ((ca == t_rdata) && (ca != lcpa_pkg::SEP_CHAR) && (ca != lcpa_pkg::UNK_CHAR)) begin
          l_next     = l + NW'(1);
          state_next = lcpa_pkg::ST_CMP_A;
        end else begin
          state_next = lcpa_pkg::ST_STORE;
        end
      end
      lcpa_pkg::ST_STORE: begin
        p_we       = 1'b1;
        p_waddr    = kreg - AW'(1);
        p_wdata    = lcpa_pkg::LCP_W'(l);
        l_next     = (l != '0) ? l - NW'(1) : l;
        cnt_next   = cnt + NW'(1);
        state_next = lcpa_pkg::ST_WALK_RANK;
      end
      lcpa_pkg::ST_DONE: begin
        results_ready_next = 1'b1;
        rsp_next           = '{lcp_value: '0, status: 1'b0};
        rsp_valid_next     = 1'b1;
        state_next         = lcpa_pkg::ST_IDLE;
      end
      default: begin
        state_next = lcpa_pkg::ST_IDLE;
      end
    endcase

    // text_length write invalidates earlier results
    if (cfg_fire) begin
      text_length_next   = cfg_data;
      results_ready_next = 1'b0;
    end
  end

  // an error word never carries an lcp value
  `ASSERT_NEVER(a_err_value, clk, rst, rsp_valid && rsp.status && (rsp.lcp_value != '0))
  // results become readable only at the end of a run
  `ASSERT_PROP(a_ready_src, clk, rst, $rose(results_ready) |-> ($past(state) == lcpa_pkg::ST_DONE))
  // the carried match length never passes the text length
  `ASSERT_PROP(a_len_bound, clk, rst, (state == lcpa_pkg::ST_CMP_A) |-> (l <= n))
  // position counter stays within the text during the walk
  `ASSERT_PROP(a_cnt_bound, clk, rst, (state == lcpa_pkg::ST_WALK_RANK) |-> (cnt <= n))
  // an lcp entry is stored only for a rank with a predecessor
  `ASSERT_PROP(a_store_rank, clk, rst, (state == lcpa_pkg::ST_STORE) |-> (kreg != '0))

endmodule

`default_nettype wire

/* hw/rtl/lcpa_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module lcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sim/lcp_array_from_suffix_array_tb.sv */
// self-checking testbench for the kasai lcp array engine
// depends on lcpa_pkg and lcp_array_from_suffix_array; a scoreboard class predicts
// every response word, plain tasks drive the command and text_length ports
`default_nettype none

module lcp_array_from_suffix_array_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // func code with no operation behind it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // response status codes
  localparam logic RSP_OK  = 1'b0;
  localparam logic RSP_ERR = 1'b1;

  localparam int unsigned IDLE_PCT       = 29;
  localparam int unsigned ITEM_TARGET    = 1350;
  localparam int unsigned CALM_FROM      = 600;   // no idling on either side in this window
  localparam int unsigned CALM_TO        = 820;
  localparam int unsigned HOLD_AT        = 450;   // response words seen before the long hold
  localparam int unsigned HOLD_LEN       = 260;
  localparam int unsigned WATCHDOG_LIMIT = 60000; // largest run is 160 bytes
  localparam int unsigned TAIL_CYCLES    = 16;

  // directed job: separator, unknown base and one out-of-range suffix entry
  localparam logic [55:0] DIR_TEXT = "AANA$AA";
  localparam logic [15:0] DIR_SA [7] = '{16'd4, 16'd6, 16'd5, 16'd0, 16'd1, 16'hFFFF, 16'd2};
  localparam logic [31:0] BASES = "ACGT";

  // predicts the response word of every accepted command word and checks the
  // words that come back in order
  class lcp_scoreboard;
    bit [lcpa_pkg::SYM_W-1:0] text_mem [lcpa_pkg::POS_SPACE];
    bit [lcpa_pkg::POS_W-1:0] sa_mem   [lcpa_pkg::POS_SPACE];
    bit [lcpa_pkg::LCP_W-1:0] lcp_mem  [lcpa_pkg::POS_SPACE];
    int unsigned              len_reg;
    bit                       lcp_valid;
    lcpa_pkg::rsp_t           want_q [$];
    int unsigned              errors;

    function int unsigned eff_len();
      int unsigned n;
      n = len_reg;
      if (n > lcpa_pkg::MAX_TEXT_DEF) n = lcpa_pkg::MAX_TEXT_DEF;
      if (n > lcpa_pkg::POS_SPACE) n = lcpa_pkg::POS_SPACE;
      return n;
    endfunction

    function void set_length(input logic [lcpa_pkg::CFG_W-1:0] v);
      len_reg   = v;
      lcp_valid = 1'b0;
    endfunction

    // inverse suffix array, then the carried-length walk in text order
    function void build_lcp();
      int unsigned n, i, k, j, l;
      int unsigned rank_of [];
      n = eff_len();
      rank_of = new[n];
      for (i = 0; i < n; i++) lcp_mem[i] = '0;
      for (i = 0; i < n; i++) begin
        if (sa_mem[i] < n) rank_of[sa_mem[i]] = i;
      end
      l = 0;
      for (i = 0; i < n; i++) begin
        k = rank_of[i];
        if (k != 0) begin
          j = sa_mem[k-1];
          while (i + l < n && j + l < n && text_mem[i+l] == text_mem[j+l] &&
                 text_mem[i+l] != lcpa_pkg::SEP_CHAR &&
                 text_mem[i+l] != lcpa_pkg::UNK_CHAR) l++;
          lcp_mem[k-1] = l[lcpa_pkg::LCP_W-1:0];
        end
        if (l > 0) l--;
      end
      lcp_valid = 1'b1;
    endfunction

    function void note(input lcpa_pkg::cmd_t w);
      lcpa_pkg::rsp_t r;
      int unsigned    n;
      r = '0;
      r.status = RSP_OK;
      case (w.func)
        lcpa_pkg::FUNC_LOAD: begin
          lcp_valid = 1'b0;
          if (w.position < lcpa_pkg::MAX_TEXT_DEF) begin
            text_mem[w.position] = w.symbol;
            sa_mem[w.position]   = w.suffix_start;
          end else begin
            r.status = RSP_ERR;
          end
        end
        lcpa_pkg::FUNC_RUN: build_lcp();
        lcpa_pkg::FUNC_READ: begin
          n = eff_len();
          if (lcp_valid && n >= 2 && w.position < n - 1) r.lcp_value = lcp_mem[w.position];
          else r.status = RSP_ERR;
        end
        default: r.status = RSP_ERR;
      endcase
      want_q = {want_q, r};
    endfunction

    function void check(input lcpa_pkg::rsp_t got);
      lcpa_pkg::rsp_t want;
      if (want_q.size() == 0) begin
        $display("%0t: response word with nothing pending: lcp_value %0d status %0d",
                 $time, got.lcp_value, got.status);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.lcp_value !== want.lcp_value) begin
        $display("%0t: lcp_value mismatch: expected %0d actual %0d",
                 $time, want.lcp_value, got.lcp_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_stall;
  lcpa_pkg::cmd_t             cmd_word  = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  lcpa_pkg::rsp_t             rsp_word;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [lcpa_pkg::CFG_W-1:0] cfg_data  = '0;

  lcp_scoreboard book = new();

  int unsigned items_sent = 0;
  int unsigned words_back = 0;
  bit          calm       = 1'b0;

  // per-job text and suffix array as the stimulus builds them
  int unsigned    job_n;
  logic [7:0]     job_text [$];
  int unsigned    job_sa   [$];

  lcp_array_from_suffix_array dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one command word, with random idle cycles in front of it, and wait
  // until the engine takes it
  task automatic send_cmd(input logic [1:0] f, input logic [15:0] p,
                          input logic [7:0] s, input logic [15:0] sa);
    lcpa_pkg::cmd_t w;
    w.func         = f;
    w.position     = p;
    w.symbol       = s;
    w.suffix_start = sa;
    calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    book.note(w);
    items_sent++;
  endtask

  // stray word: unused func, a read or a load at any position
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_cmd(FUNC_UNUSED, 16'($urandom), 8'($urandom), 16'($urandom));
      1: send_cmd(lcpa_pkg::FUNC_READ, 16'($urandom), 8'($urandom), 16'($urandom));
      default: send_cmd(lcpa_pkg::FUNC_LOAD, 16'($urandom), 8'($urandom), 16'($urandom));
    endcase
  endtask

  // stop offering and wait until every response word is back, so the engine is idle
  task automatic drain_engine();
    cmd_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_length(input logic [lcpa_pkg::CFG_W-1:0] v);
    drain_engine();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_length(v);
    cfg_valid <= 1'b0;
  endtask

  // mostly bases, some terminators, a few arbitrary bytes; flavor 1 repeats a
  // short period so matches run long, flavor 2 gives arbitrary bytes only
  function automatic logic [7:0] pick_symbol(input int unsigned flavor, input int unsigned pos,
                                             input int unsigned period);
    int unsigned r;
    r = $urandom_range(99);
    if (flavor == 2) return 8'($urandom);
    if (r < 5) return lcpa_pkg::SEP_CHAR;
    if (r < 9) return lcpa_pkg::UNK_CHAR;
    if (flavor == 1) return BASES[8*(pos % period) +: 8];
    if (r < 13) return 8'($urandom);
    return BASES[8*$urandom_range(3) +: 8];
  endfunction

  // lexicographic order of two suffixes of the job text, shorter first on a tie
  function automatic bit suffix_less(input int unsigned a, input int unsigned b);
    while (a < job_n && b < job_n) begin
      if (job_text[a] != job_text[b]) return job_text[a] < job_text[b];
      a++;
      b++;
    end
    return a >= job_n && b < job_n;
  endfunction

  function automatic int unsigned pick_n(input int unsigned job_idx);
    int unsigned r;
    r = $urandom_range(99);
    if (job_idx == 6) return 160;
    if (r < 5) return $urandom_range(1);
    if (r < 90) return $urandom_range(2, 24);
    return $urandom_range(25, 64);
  endfunction

  // one job: length, every position loaded, run, then reads with a few
  // broken steps mixed in
  task automatic run_job(input int unsigned n);
    int unsigned flavor, period, sa_flavor, i, p, tmp, reads, r;
    int unsigned order [$];
    write_length(n);
    flavor    = $urandom_range(2);
    period    = $urandom_range(1, 4);
    sa_flavor = $urandom_range(9);
    job_n     = n;
    job_text.delete();
    job_sa.delete();
    order.delete();
    for (i = 0; i < n; i++) begin
      job_text = {job_text, pick_symbol(flavor, i, period)};
      job_sa   = {job_sa, i};
      order    = {order, i};
    end
    for (i = n; i > 1; i--) begin
      p = $urandom_range(i - 1);
      tmp = job_sa[i-1]; job_sa[i-1] = job_sa[p]; job_sa[p] = tmp;
    end
    if (sa_flavor < 5) begin
      // a true suffix array, by insertion sort
      for (i = 1; i < n; i++) begin
        tmp = job_sa[i];
        p = i;
        while (p > 0 && suffix_less(tmp, job_sa[p-1])) begin
          job_sa[p] = job_sa[p-1];
          p--;
        end
        job_sa[p] = tmp;
      end
    end else if (sa_flavor >= 8) begin
      // some entries point past the end of the text
      for (i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0) job_sa[i] = $urandom_range(65535, n);
      end
    end
    if ($urandom_range(9) < 7) begin
      for (i = n; i > 1; i--) begin
        p = $urandom_range(i - 1);
        tmp = order[i-1]; order[i-1] = order[p]; order[p] = tmp;
      end
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 6) send_noise();
      p = order[i];
      send_cmd(lcpa_pkg::FUNC_LOAD, 16'(p), job_text[p], 16'(job_sa[p]));
    end
    // read before the run
    if ($urandom_range(9) == 0)
      send_cmd(lcpa_pkg::FUNC_READ, 16'($urandom_range(n)), 8'($urandom), '0);
    send_cmd(lcpa_pkg::FUNC_RUN, 16'($urandom), 8'($urandom), 16'($urandom));
    reads = (n > 30 ? 30 : n) + 2 + $urandom_range(n > 8 ? 8 : n);
    for (i = 0; i < reads; i++) begin
      r = $urandom_range(99);
      if (r < 80)
        send_cmd(lcpa_pkg::FUNC_READ, 16'($urandom_range(n)), 8'($urandom),
                 16'($urandom));
      else if (r < 88)
        send_cmd(lcpa_pkg::FUNC_READ, 16'($urandom), 8'($urandom), 16'($urandom));
      else if (r < 94)
        send_cmd(lcpa_pkg::FUNC_RUN, 16'($urandom), 8'($urandom), 16'($urandom));
      else send_noise();
    end
  endtask

  // lengths far beyond what is loaded: only loads, reads and unused funcs, never a run
  task automatic wide_length_phase(input logic [lcpa_pkg::CFG_W-1:0] v);
    int unsigned i;
    write_length(v);
    for (i = 0; i < 8; i++) send_noise();
    send_cmd(lcpa_pkg::FUNC_READ, 16'($urandom_range(63)), '0, '0);
  endtask

  // receiver: checks every word taken, stalls at random, holds off once for a
  // long stretch so the engine backs up into the command channel
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        book.check(rsp_word);
        words_back++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!held && words_back >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog: too many cycles without any word moving ends the run
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned i, job_idx;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    write_length('0);
    send_cmd(lcpa_pkg::FUNC_READ, '0, '0, '0);                   // read before any run
    send_cmd(FUNC_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);            // unused func, all ones
    send_cmd(lcpa_pkg::FUNC_LOAD, 16'hFFFF, 8'hFF, 16'hFFFF);    // top position, extreme fields
    send_cmd(lcpa_pkg::FUNC_RUN, '0, '0, '0);                    // empty text
    send_cmd(lcpa_pkg::FUNC_READ, '0, '0, '0);                   // no rank pair exists
    write_length(17'd1);
    send_cmd(lcpa_pkg::FUNC_LOAD, '0, 8'h41, '0);
    send_cmd(lcpa_pkg::FUNC_RUN, '0, '0, '0);
    send_cmd(lcpa_pkg::FUNC_READ, '0, '0, '0);
    write_length(17'd7);
    for (i = 0; i < 7; i++)
      send_cmd(lcpa_pkg::FUNC_LOAD, 16'(i), DIR_TEXT[8*(6-i) +: 8], DIR_SA[i]);
    send_cmd(lcpa_pkg::FUNC_RUN, '0, '0, '0);
    // last one is out of range
    for (i = 0; i < 7; i++) send_cmd(lcpa_pkg::FUNC_READ, 16'(i), '0, '0);
    send_cmd(lcpa_pkg::FUNC_READ, 16'hFFFF, '0, '0);

    // random jobs, with the widest lengths visited in between
    job_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      job_idx++;
      if (job_idx == 4) wide_length_phase(17'h1FFFF);
      if (job_idx == 14) wide_length_phase(17'h10000);
      if (job_idx == 24) wide_length_phase(17'h0FFFF);
      run_job(pick_n(job_idx));
    end

    drain_engine();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
